[sv/dplru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dplru_pkg
// Shared widths, codes, defaults and word types of the demand-paging LRU MMU.
// ----------------------------------------------------------------------------
package dplru_pkg;

  // fixed field widths
  localparam int VA_W      = 22;
  localparam int RA_W      = 16;
  localparam int VICTIM_W  = 10;

  // parameter defaults
  localparam int OFFSET_BITS_DEF   = 12;
  localparam int VIRTUAL_PAGES_DEF = 1024;
  localparam int RAM_FRAMES_DEF    = 16;

  // access codes
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [VA_W-1:0] vaddr;
  } dplru_in_t;

  typedef struct packed {
    logic [RA_W-1:0]     paddr;
    logic                hit;
    logic                evicted;
    logic [VICTIM_W-1:0] victim_page;
    logic                write_back;
  } dplru_out_t;

endpackage
`default_nettype wire

[sv/dplru_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dplru_ram
// Generic RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/demand_paging_lru_mmu_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_lru_mmu_core
// Demand-paging MMU with least-recently-used frame replacement.
// ----------------------------------------------------------------------------
// Each input word is one byte access; each gives one result word with the
// physical address and the fill, eviction and write-back commands. After
// reset the block runs a clearing pass over the page table, one entry per
// cycle, with in_stall high. An access then passes through accept and the
// page-table read-modify-write when it hits or gets a free frame, and through
// a further write state when it evicts, since the victim's page-table entry is
// cleared in a write of its own on the single write port. With a VIRTUAL_PAGES
// that is not a power of two, an extra state (S_MOD) reduces the page number
// before the table read. The result waits in an output register; a new word
// is accepted while it waits, and the lookup holds until the register is free.
// ----------------------------------------------------------------------------
module demand_paging_lru_mmu_core
  import dplru_pkg::*;
#(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int VIRTUAL_PAGES = VIRTUAL_PAGES_DEF,
  parameter int RAM_FRAMES    = RAM_FRAMES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dplru_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dplru_out_t      out_data
);

  localparam int RAW_W   = VA_W - OFFSET_BITS;
  localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
  localparam int FRAME_W = $clog2(RAM_FRAMES);
  localparam int CNT_W   = $clog2(RAM_FRAMES + 1);
  localparam int ENT_W   = FRAME_W + 1;
  localparam bit VP_POW2 = (VIRTUAL_PAGES & (VIRTUAL_PAGES - 1)) == 0;
  // reciprocal for the page-number reduction: exact floor for RAW_W-bit values
  localparam int REC_SH  = RAW_W + PAGE_W;
  localparam int MUL_W   = 2 * RAW_W + 2;
  localparam logic [63:0] REC_M =
    ((64'd1 << REC_SH) + 64'(VIRTUAL_PAGES) - 64'd1) / 64'(VIRTUAL_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_EVICT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PAGE_W-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]       frames_used_r, frames_used_nxt;
  logic                   out_valid_r, out_valid_nxt;
  dplru_out_t             out_data_r, out_data_nxt;
  logic [PAGE_W-1:0]      page_r, page_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic                   wr_r, wr_nxt;
  logic [RAW_W-1:0]       raw_r, raw_nxt;
  logic [RAW_W-1:0]       q_r, q_nxt;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;
  logic [FRAME_W-1:0]     rec_r [RAM_FRAMES];
  logic [FRAME_W-1:0]     rec_nxt [RAM_FRAMES];
  logic [RAM_FRAMES-1:0]  dirty_r, dirty_nxt;

  logic                   accept;
  logic [RAW_W-1:0]       raw_in;
  logic [PAGE_W-1:0]      page_in;
  logic [MUL_W-1:0]       rec_prod;
  logic [RAW_W-1:0]       qvp;
  logic [PAGE_W-1:0]      page_mod;

  logic                   pt_we, pt_re;
  logic [PAGE_W-1:0]      pt_waddr, pt_raddr;
  logic [ENT_W-1:0]       pt_wdata, pt_rdata;
  logic                   fo_we, fo_re;
  logic [FRAME_W-1:0]     fo_waddr;
  logic [PAGE_W-1:0]      fo_rdata;

  logic                   look_go;
  logic                   hit, free, evict;
  logic [FRAME_W-1:0]     ent_frame, lru, frame_sel;
  logic [RAM_FRAMES-1:0]  match;
  logic [31:0]            pa32, victim32;

  assign accept  = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;

  // page number, reduced modulo the table depth
  assign raw_in   = in_data.vaddr[VA_W-1:OFFSET_BITS];
  assign page_in  = PAGE_W'(raw_in);
  assign rec_prod = MUL_W'(raw_in) * MUL_W'(REC_M);
  assign qvp      = q_r * RAW_W'(VIRTUAL_PAGES);
  assign page_mod = PAGE_W'(raw_r - qvp);

  // lookup decode
  assign lru       = rec_r[RAM_FRAMES-1];
  assign hit       = pt_rdata[FRAME_W];
  assign ent_frame = pt_rdata[FRAME_W-1:0];
  assign free      = frames_used_r < CNT_W'(RAM_FRAMES);
  assign evict     = !hit && !free;
  assign frame_sel = hit ? ent_frame : (free ? FRAME_W'(frames_used_r) : lru);
  assign look_go   = (state_r == S_LOOK) && (!out_valid_r || !out_stall);
  assign pa32      = 32'({frame_sel, off_r});
  assign victim32  = 32'(fo_rdata);

  // memory ports
  assign pt_re    = ((state_r == S_IDLE) && accept && VP_POW2) || (state_r == S_MOD);
  assign fo_re    = pt_re;
  assign pt_raddr = (state_r == S_IDLE) ? page_in : page_mod;

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = page_r;
    pt_wdata = {1'b1, frame_sel};
    case (state_r)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_r;
        pt_wdata = '0;
      end
      S_LOOK: begin
        pt_we = look_go;
        // clear the victim's entry first
        if (evict) begin
          pt_waddr = fo_rdata;
          pt_wdata = '0;
        end
      end
      S_EVICT: begin
        pt_we    = 1'b1;
        pt_wdata = {1'b1, frame_r};
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  assign fo_we    = look_go && !hit;
  assign fo_waddr = frame_sel;

  // recency row: move the used frame to the front
  always_comb begin
    logic [RAM_FRAMES-1:0] lowm;
    logic                  ahead;
    logic                  shift;
    for (int i = 0; i < RAM_FRAMES; i++) begin
      match[i] = (rec_r[i] == ent_frame) && (CNT_W'(i) < frames_used_r);
    end
    rec_nxt[0] = frame_sel;
    for (int i = 1; i < RAM_FRAMES; i++) begin
      lowm  = ~({RAM_FRAMES{1'b1}} << i);
      ahead = |(match & lowm);
      if (hit) begin
        shift = !ahead;
      end else if (free) begin
        shift = CNT_W'(i) <= frames_used_r;
      end else begin
        shift = 1'b1;
      end
      rec_nxt[i] = shift ? rec_r[i-1] : rec_r[i];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    frames_used_nxt = frames_used_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    page_nxt        = page_r;
    off_nxt         = off_r;
    wr_nxt          = wr_r;
    raw_nxt         = raw_r;
    q_nxt           = q_r;
    frame_nxt       = frame_r;
    dirty_nxt       = dirty_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PAGE_W'(VIRTUAL_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          page_nxt  = page_in;
          off_nxt   = in_data.vaddr[OFFSET_BITS-1:0];
          wr_nxt    = in_data.opcode == OP_WRITE;
          raw_nxt   = raw_in;
          q_nxt     = RAW_W'(rec_prod >> REC_SH);
          state_nxt = VP_POW2 ? S_LOOK : S_MOD;
        end
      end
      S_MOD: begin
        page_nxt  = page_mod;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (look_go) begin
          frame_nxt     = frame_sel;
          out_valid_nxt = 1'b1;
          out_data_nxt.paddr       = pa32[RA_W-1:0];
          out_data_nxt.hit         = hit;
          out_data_nxt.evicted     = evict;
          out_data_nxt.victim_page = evict ? victim32[VICTIM_W-1:0] : '0;
          out_data_nxt.write_back  = evict && dirty_r[lru];
          dirty_nxt[frame_sel]     = hit ? (dirty_r[frame_sel] | wr_r) : wr_r;
          if (!hit && free) begin
            frames_used_nxt = frames_used_r + 1'b1;
          end
          state_nxt = evict ? S_EVICT : S_IDLE;
        end
      end
      S_EVICT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      frames_used_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      frames_used_r <= frames_used_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    page_r     <= page_nxt;
    off_r      <= off_nxt;
    wr_r       <= wr_nxt;
    raw_r      <= raw_nxt;
    q_r        <= q_nxt;
    frame_r    <= frame_nxt;
    dirty_r    <= dirty_nxt;
    if (look_go) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dplru_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VIRTUAL_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  dplru_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (RAM_FRAMES)
  ) u_frame_owner (
    .clk   (clk),
    .we    (fo_we),
    .waddr (fo_waddr),
    .wdata (page_r),
    .re    (fo_re),
    .raddr (lru),
    .rdata (fo_rdata)
  );

  // frame count stays within the frame pool
  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_used_r <= CNT_W'(RAM_FRAMES))
    else $error("frame count beyond pool");

  // frames are never handed back
  a_frames_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> frames_used_r >= $past(frames_used_r))
    else $error("frame count decreased");

  // eviction only once every frame is in use
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    look_go && evict |-> frames_used_r == CNT_W'(RAM_FRAMES))
    else $error("eviction with free frames left");

  // write-back only on an eviction
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.write_back |-> out_data_r.evicted)
    else $error("write-back without eviction");

  // an eviction is followed by the second page-table write
  a_evict_seq: assert property (@(posedge clk) disable iff (!rst_n)
    look_go && evict |=> state_r == S_EVICT && pt_we && pt_wdata[FRAME_W])
    else $error("missing fill write after eviction");

endmodule
`default_nettype wire

[dv/demand_paging_lru_mmu_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_lru_mmu_core_test
// Self-checking bench for the demand-paging LRU MMU core. A directed table
// covers first fills, hits, write misses and dirty and clean evictions. Random
// accesses follow, drawn mostly from a shifting working set of pages so that
// hits and LRU evictions both occur often. Every result word is compared to
// a literal or a page-table and recency model, with random gaps on both sides.
// ----------------------------------------------------------------------------
module demand_paging_lru_mmu_core_test;
  import dplru_pkg::*;

  localparam logic OP_READ      = 1'b0;
  localparam int   NUM_PAGES    = VIRTUAL_PAGES_DEF;
  localparam int   NUM_FRAMES   = RAM_FRAMES_DEF;
  localparam int   RANDOM_ITEMS = 2000;
  localparam int   MAX_GAP      = 17;
  localparam int   DRAIN_CYCLES = 20;

  typedef struct {
    logic            opcode;
    logic [VA_W-1:0] vaddr;
    bit              literal_ok;
    dplru_out_t      literal;
  } access_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  dplru_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  dplru_out_t out_data;

  demand_paging_lru_mmu_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // page table and recency model
  bit         pte_present [NUM_PAGES];
  bit         pte_dirty   [NUM_PAGES];
  int         pte_frame   [NUM_PAGES];
  int         frame_owner [NUM_FRAMES];
  int         lru_order   [NUM_FRAMES];
  int         frames_used;

  dplru_out_t  pending_results[$];
  access_row_t directed[$];
  int          mismatches;
  bit          quiet;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shift positions [0, upto) down one place and put frame at the front.
  function automatic void move_to_front(input int upto, input int frame);
    for (int i = upto; i > 0; i--) lru_order[i] = lru_order[i-1];
    lru_order[0] = frame;
  endfunction

  function automatic dplru_out_t translate_access(input logic op,
                                                  input logic [VA_W-1:0] va);
    int         page;
    int         offs;
    int         frame;
    int         pos;
    int         victim;
    dplru_out_t r;
    page   = (int'(va) >> OFFSET_BITS_DEF) % NUM_PAGES;
    offs   = int'(va) & ((1 << OFFSET_BITS_DEF) - 1);
    r      = '0;
    victim = 0;
    if (pte_present[page]) begin
      r.hit = 1'b1;
      frame = pte_frame[page];
      pos   = 0;
      for (int i = 0; i < frames_used; i++) begin
        if (lru_order[i] == frame) begin
          pos = i;
          break;
        end
      end
      move_to_front(pos, frame);
    end else if (frames_used < NUM_FRAMES) begin
      frame = frames_used;
      move_to_front(frames_used, frame);
      frames_used++;
    end else begin
      // evict the least recent page and reuse its frame
      frame               = lru_order[NUM_FRAMES-1];
      victim              = frame_owner[frame] % NUM_PAGES;
      r.evicted           = 1'b1;
      r.write_back        = pte_dirty[victim];
      pte_present[victim] = 1'b0;
      pte_dirty[victim]   = 1'b0;
      pte_frame[victim]   = 0;
      move_to_front(NUM_FRAMES - 1, frame);
    end
    if (!r.hit) begin
      pte_present[page]  = 1'b1;
      pte_dirty[page]    = 1'b0;
      pte_frame[page]    = frame;
      frame_owner[frame] = page;
    end
    if (op == OP_WRITE) pte_dirty[page] = 1'b1;
    r.paddr       = RA_W'(((frame << OFFSET_BITS_DEF) | offs) & 32'hFFFF);
    r.victim_page = VICTIM_W'(victim);
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [VA_W-1:0] va,
                         input bit literal_ok, input dplru_out_t literal);
    access_row_t row;
    row.opcode     = op;
    row.vaddr      = va;
    row.literal_ok = literal_ok;
    row.literal    = literal;
    directed.push_back(row);
  endtask

  // Enter and leave at a falling edge.
  task automatic send_access(input logic op, input logic [VA_W-1:0] va,
                             input bit literal_ok, input dplru_out_t literal);
    int         gap;
    dplru_out_t predicted;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, vaddr: va};
    do @(posedge clk); while (in_stall);
    predicted = translate_access(op, va);
    pending_results.push_back(literal_ok ? literal : predicted);
    @(negedge clk);
  endtask

  task automatic check_result(input dplru_out_t got);
    dplru_out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: paddr %h hit %b", got.paddr, got.hit);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t ns:", $realtime);
        $display("  paddr exp %h got %h", want.paddr, got.paddr);
        $display("  hit exp %b got %b, evicted exp %b got %b",
                 want.hit, got.hit, want.evicted, got.evicted);
        $display("  victim_page exp %0d got %0d, write_back exp %b got %b",
                 want.victim_page, got.victim_page, want.write_back, got.write_back);
      end
    end
  endtask

  // result side: random stall per word, then wait for the word
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  initial begin
    #5_000_000;
    $display("demand_paging_lru_mmu_core_test failed");
    $finish;
  end

  initial begin
    int               pool[32];
    int               pool_size;
    int               page;
    int               last_page;
    int               pick;
    logic             op;
    logic [VA_W-1:0]  va;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    mismatches = 0;
    frames_used = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      pte_present[i] = 1'b0;
      pte_dirty[i]   = 1'b0;
      pte_frame[i]   = 0;
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_owner[i] = 0;
      lru_order[i]   = 0;
    end

    // first fills, hits, hit on most recent page
    add_row(OP_READ,  22'h000000, 1'b1, '{16'h0000, 1'b0, 1'b0, 10'd0, 1'b0});
    add_row(OP_WRITE, 22'h3FFFFF, 1'b1, '{16'h1FFF, 1'b0, 1'b0, 10'd0, 1'b0});
    add_row(OP_READ,  22'h3FF000, 1'b1, '{16'h1000, 1'b1, 1'b0, 10'd0, 1'b0});
    add_row(OP_READ,  22'h3FF123, 1'b1, '{16'h1123, 1'b1, 1'b0, 10'd0, 1'b0});
    add_row(OP_WRITE, 22'h000FFF, 1'b1, '{16'h0FFF, 1'b1, 1'b0, 10'd0, 1'b0});
    // use up the free frames, alternating reads and write misses
    for (int p = 2; p < NUM_FRAMES; p++)
      add_row(p[0] ? OP_WRITE : OP_READ, {p[9:0], 12'hA5C}, 1'b0, '0);
    // dirty evictions, a hit reordering, clean eviction, refill of evicted pages
    add_row(OP_READ,  22'h200000, 1'b0, '0);
    add_row(OP_WRITE, 22'h201555, 1'b0, '0);
    add_row(OP_READ,  22'h002AAA, 1'b0, '0);
    add_row(OP_READ,  22'h3FE001, 1'b0, '0);
    add_row(OP_WRITE, 22'h3FFFFF, 1'b0, '0);
    add_row(OP_READ,  22'h000000, 1'b0, '0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_access(directed[i].opcode, directed[i].vaddr,
                  directed[i].literal_ok, directed[i].literal);

    pool_size = 16;
    last_page = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      // shift the working set: small sets mostly hit, large ones thrash
      if (n % 250 == 0) begin
        pool_size = $urandom_range(8, 30);
        for (int i = 0; i < 32; i++) pool[i] = $urandom_range(0, NUM_PAGES - 1);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)       page = pool[$urandom_range(0, pool_size - 1)];
      else if (pick < 8)  page = last_page;
      else                page = $urandom_range(0, NUM_PAGES - 1);
      last_page = page;
      op = $urandom_range(0, 1);
      va = {page[9:0], 12'($urandom_range(0, 4095))};
      send_access(op, va, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("demand_paging_lru_mmu_core_test passed");
    end else begin
      $display("demand_paging_lru_mmu_core_test failed");
    end
    $finish;
  end

endmodule
